// File: src/tape_machine_interpreter_assert.svh
// Assertion macros shared by the tape machine interpreter RTL.
`ifndef TAPE_MACHINE_INTERPRETER_ASSERT_SVH
`define TAPE_MACHINE_INTERPRETER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TMI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tmi_pkg.sv
// Shared constants, types and command codes of the tape machine interpreter.
package tmi_pkg;

    // Store sizes and the widths that follow from them.
    localparam int PROG_DEPTH = 1024;
    localparam int TAPE_DEPTH = 16384;
    localparam int PROG_AW    = $clog2(PROG_DEPTH);
    localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
    localparam int PC_W       = $clog2(PROG_DEPTH + 1);

    // Fixed widths of the interface fields.
    localparam int LEN_W  = 11;
    localparam int BYTE_W = 8;

    // Request kinds.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Program characters with a meaning.
    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

    // Access to the data tape from the sequencer.
    typedef struct packed {
        logic               we;
        logic [TAPE_AW-1:0] addr;
        logic [BYTE_W-1:0]  wdata;
    } tmi_tape_req_t;

endpackage

// File: src/tmi_tape.sv
// Data tape memory with its clearing sweep after reset.
module tmi_tape
    import tmi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tmi_tape_req_t       req,
    output logic [BYTE_W-1:0]   rdata,
    output logic                ready
);

    logic [BYTE_W-1:0]  mem [TAPE_DEPTH];
    logic [TAPE_AW-1:0] clr_addr_reg;
    logic [TAPE_AW-1:0] clr_addr_next;
    logic               clearing_reg;
    logic               clearing_next;
    logic               mem_we;
    logic [TAPE_AW-1:0] mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;

    // The sweep writes zero to one cell per cycle until the last cell is done.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == TAPE_AW'(TAPE_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

    // The write port is owned by the sweep until it finishes.
    assign mem_we    = clearing_reg | req.we;
    assign mem_waddr = clearing_reg ? clr_addr_reg : req.addr;
    assign mem_wdata = clearing_reg ? '0 : req.wdata;

    // Single write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata <= mem[req.addr];
    end

    assign ready = ~clearing_reg;

endmodule

// File: src/tape_machine_interpreter.sv
// Top level of the tape machine interpreter: program store and sequencer.
//
//  channel   direction  handshake               word
//  in        input      in_valid / in_stall     req_type, prog_addr, prog_char, in_byte
//  result    output     res_valid / res_stall   out_valid, out_byte, halted, next_pc
//  cfg       input      cfg_wr_en               cfg_wr_data (program length)
//
// A load word passes through the finish state only, and a plain instruction through the
// exec and finish states, with one memory read and one write-back of the tape cell. A
// taken bracket adds a scan state that walks the program, in which the program store
// yields one character per cycle; a forward scan with no match stops at the length.
// After reset the tape is swept to zero; in_stall stays high until the sweep is over.
// A waiting result does not block the next word; a finished word waits for the result
// register only if that is still held.
module tape_machine_interpreter
    import tmi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  logic [PROG_AW-1:0]  prog_addr,
    input  logic [BYTE_W-1:0]   prog_char,
    input  logic [BYTE_W-1:0]   in_byte,
    output logic                res_valid,
    input  logic                res_stall,
    output logic                out_valid,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                halted,
    output logic [PC_W-1:0]     next_pc
);

`include "tape_machine_interpreter_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_F,
        S_SCAN_B,
        S_FINISH
    } state_t;

    state_t              state_reg,     state_next;
    logic [PC_W-1:0]     pc_reg,        pc_next;
    logic [TAPE_AW-1:0]  dp_reg,        dp_next;
    logic [PC_W-1:0]     len_reg,       len_next;
    logic [PC_W-1:0]     scan_reg,      scan_next;
    logic [PC_W-1:0]     depth_reg,     depth_next;
    logic [BYTE_W-1:0]   ibyte_reg,     ibyte_next;
    logic                emit_reg,      emit_next;
    logic [BYTE_W-1:0]   emit_byte_reg, emit_byte_next;
    logic                res_valid_reg, res_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg,  out_byte_next;
    logic                halted_reg,    halted_next;
    logic [PC_W-1:0]     npc_reg,       npc_next;

    logic [BYTE_W-1:0]   prog_mem [PROG_DEPTH];
    logic [BYTE_W-1:0]   instr;
    logic [PROG_AW-1:0]  prog_raddr;
    logic                prog_we;
    logic                accept;
    logic [PC_W-1:0]     pc_inc;
    logic [PC_W-1:0]     scan_inc;
    logic [PC_W-1:0]     scan_dec;
    tmi_tape_req_t       tape_req;
    logic [BYTE_W-1:0]   cell_data;
    logic                tape_ready;

    // Data tape with its reset sweep.
    tmi_tape u_tape (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tape_req),
        .rdata (cell_data),
        .ready (tape_ready)
    );

    assign in_stall = (state_reg != S_IDLE) | ~tape_ready;
    assign accept   = in_valid & ~in_stall;
    assign pc_inc   = pc_reg + 1'b1;
    assign scan_inc = scan_reg + 1'b1;
    assign scan_dec = scan_reg - 1'b1;

    // Program store: written by load words, read one character per cycle.
    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[prog_addr] <= prog_char;
        end
        instr <= prog_mem[prog_raddr];
    end

    // Tape access always addresses the current cell; only the cell commands write.
    always_comb
    begin
        tape_req.addr  = dp_reg;
        tape_req.we    = 1'b0;
        tape_req.wdata = cell_data;
        if (state_reg == S_EXEC)
        begin
            case (instr)
                CH_INC:
                begin
                    tape_req.we    = 1'b1;
                    tape_req.wdata = cell_data + 1'b1;
                end
                CH_DEC:
                begin
                    tape_req.we    = 1'b1;
                    tape_req.wdata = cell_data - 1'b1;
                end
                CH_IN:
                begin
                    tape_req.we    = 1'b1;
                    tape_req.wdata = ibyte_reg;
                end
                default:
                begin
                    tape_req.we = 1'b0;
                end
            endcase
        end
    end

    // Sequencer: decode, bracket scans and the result register.
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        dp_next        = dp_reg;
        len_next       = len_reg;
        scan_next      = scan_reg;
        depth_next     = depth_reg;
        ibyte_next     = ibyte_reg;
        emit_next      = emit_reg;
        emit_byte_next = emit_byte_reg;
        res_valid_next = res_valid_reg & res_stall;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        halted_next    = halted_reg;
        npc_next       = npc_reg;
        prog_raddr     = pc_reg[PROG_AW-1:0];
        prog_we        = 1'b0;

        // The length register saturates at the store depth.
        if (cfg_wr_en)
        begin
            if (32'(cfg_wr_data) > 32'(PROG_DEPTH))
            begin
                len_next = PC_W'(PROG_DEPTH);
            end
            else
            begin
                len_next = PC_W'(cfg_wr_data);
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    emit_next      = 1'b0;
                    emit_byte_next = '0;
                    ibyte_next     = in_byte;
                    if (req_type == REQ_LOAD)
                    begin
                        prog_we    = (32'(prog_addr) < 32'(PROG_DEPTH));
                        state_next = S_FINISH;
                    end
                    else if (pc_reg < len_reg)
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_EXEC:
            begin
                pc_next    = pc_inc;
                state_next = S_FINISH;
                case (instr)
                    CH_RIGHT:
                    begin
                        if (dp_reg == TAPE_AW'(TAPE_DEPTH - 1))
                        begin
                            dp_next = '0;
                        end
                        else
                        begin
                            dp_next = dp_reg + 1'b1;
                        end
                    end
                    CH_LEFT:
                    begin
                        if (dp_reg == '0)
                        begin
                            dp_next = TAPE_AW'(TAPE_DEPTH - 1);
                        end
                        else
                        begin
                            dp_next = dp_reg - 1'b1;
                        end
                    end
                    CH_OUT:
                    begin
                        emit_next      = 1'b1;
                        emit_byte_next = cell_data;
                    end
                    CH_OPEN:
                    begin
                        if (cell_data == '0)
                        begin
                            scan_next  = pc_inc;
                            depth_next = '0;
                            prog_raddr = pc_inc[PROG_AW-1:0];
                            state_next = S_SCAN_F;
                        end
                    end
                    CH_CLOSE:
                    begin
                        if (cell_data != '0 && pc_reg != '0)
                        begin
                            scan_next  = pc_reg - 1'b1;
                            depth_next = '0;
                            prog_raddr = scan_next[PROG_AW-1:0];
                            state_next = S_SCAN_B;
                        end
                    end
                    default:
                    begin
                        pc_next = pc_inc;
                    end
                endcase
            end

            // Forward scan: the character at scan_reg arrives in this cycle.
            S_SCAN_F:
            begin
                if (scan_reg >= len_reg)
                begin
                    pc_next    = len_reg;
                    state_next = S_FINISH;
                end
                else if (instr == CH_CLOSE && depth_reg == '0)
                begin
                    pc_next    = scan_inc;
                    state_next = S_FINISH;
                end
                else
                begin
                    if (instr == CH_OPEN)
                    begin
                        depth_next = depth_reg + 1'b1;
                    end
                    else if (instr == CH_CLOSE)
                    begin
                        depth_next = depth_reg - 1'b1;
                    end
                    scan_next  = scan_inc;
                    prog_raddr = scan_inc[PROG_AW-1:0];
                end
            end

            // Backward scan; an unmatched bracket falls through past the ']',
            // where the program counter already points.
            S_SCAN_B:
            begin
                if (instr == CH_OPEN && depth_reg == '0)
                begin
                    pc_next    = scan_inc;
                    state_next = S_FINISH;
                end
                else if (scan_reg == '0)
                begin
                    pc_next    = pc_reg;
                    state_next = S_FINISH;
                end
                else
                begin
                    if (instr == CH_CLOSE)
                    begin
                        depth_next = depth_reg + 1'b1;
                    end
                    else if (instr == CH_OPEN)
                    begin
                        depth_next = depth_reg - 1'b1;
                    end
                    scan_next  = scan_dec;
                    prog_raddr = scan_dec[PROG_AW-1:0];
                end
            end

            S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    out_valid_next = emit_reg;
                    out_byte_next  = emit_byte_reg;
                    halted_next    = (pc_reg >= len_reg);
                    npc_next       = pc_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            dp_reg        <= '0;
            len_reg       <= '0;
            scan_reg      <= '0;
            depth_reg     <= '0;
            emit_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            dp_reg        <= dp_next;
            len_reg       <= len_next;
            scan_reg      <= scan_next;
            depth_reg     <= depth_next;
            emit_reg      <= emit_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        ibyte_reg     <= ibyte_next;
        emit_byte_reg <= emit_byte_next;
        out_byte_reg  <= out_byte_next;
        halted_reg    <= halted_next;
        npc_reg       <= npc_next;
    end

    assign res_valid = res_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign halted    = halted_reg;
    assign next_pc   = npc_reg;

    // No word is taken while the tape is still being cleared.
    `TMI_ASSERT_NOW(a_no_accept_in_sweep, !tape_ready, in_stall, "word accepted during tape sweep")
    // The tape is never written while a bracket scan walks the program.
    `TMI_ASSERT_NOW(a_no_tape_write_in_scan, state_reg == S_SCAN_F || state_reg == S_SCAN_B, !tape_req.we, "tape written during scan")
    // The data pointer stays inside the tape.
    `TMI_ASSERT_NOW(a_dp_in_range, 1'b1, 32'(dp_reg) < 32'(TAPE_DEPTH), "data pointer out of range")
    // A finish step with a free output always leaves a result behind.
    `TMI_ASSERT_NEXT(a_finish_gives_result, state_reg == S_FINISH && (!res_valid_reg || !res_stall), res_valid_reg && state_reg == S_IDLE, "finished word produced no result")

endmodule
